// ----- rtl/ssbk_pkg.sv -----
package ssbk_pkg;

	// Capacity of the record store and width of the payload carried with each key.
	localparam int MAX_RECORDS  = 64;
	localparam int PAYLOAD_BITS = 16;
	localparam int KEY_BITS     = 32;

	// Index into the store, and a count that can also hold the capacity itself.
	localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CNT_W = $clog2(MAX_RECORDS + 1);

	typedef struct packed {
		logic [KEY_BITS-1:0]     key;
		logic [PAYLOAD_BITS-1:0] payload;
	} rec_t;

	// One write port and two read ports on the record store.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		rec_t             wdata;
		logic [IDX_W-1:0] raddr_a;
		logic [IDX_W-1:0] raddr_b;
	} mem_req_t;

	// Request from the sequencer to load the output register.
	typedef struct packed {
		logic load;
		logic last;
		logic ovf;
	} emit_ctl_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_GAP,
		ST_PASS,
		ST_READ,
		ST_CMP,
		ST_SWAP,
		ST_EMIT_RD,
		ST_EMIT_WR
	} ssbk_state_t;

endpackage

// ----- rtl/ssbk_store.sv -----
module ssbk_store (
	input  logic              clk,
	input  ssbk_pkg::mem_req_t req,
	output ssbk_pkg::rec_t    rdata_a,
	output ssbk_pkg::rec_t    rdata_b
);

	// The store is not cleared; only entries written in the current set are read.
	ssbk_pkg::rec_t mem_q [ssbk_pkg::MAX_RECORDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata_a <= mem_q[req.raddr_a];
		rdata_b <= mem_q[req.raddr_b];
	end

endmodule

// ----- rtl/ssbk_seq.sv -----
module ssbk_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load_valid,
	output logic                              load_stall,
	input  logic [ssbk_pkg::KEY_BITS-1:0]     key,
	input  logic [ssbk_pkg::PAYLOAD_BITS-1:0] payload,
	input  logic                              last_in,
	input  ssbk_pkg::rec_t                    rdata_a,
	input  ssbk_pkg::rec_t                    rdata_b,
	input  logic                              out_busy,
	output ssbk_pkg::mem_req_t                mem_req,
	output ssbk_pkg::emit_ctl_t               emit
);

	ssbk_pkg::ssbk_state_t state_q, state_nxt;

	logic [ssbk_pkg::CNT_W-1:0] count_q;
	logic                       ovf_q;
	logic [ssbk_pkg::CNT_W-1:0] gap_q;
	logic [ssbk_pkg::CNT_W-1:0] i_q;
	logic [ssbk_pkg::IDX_W-1:0] j_q;
	logic [ssbk_pkg::IDX_W-1:0] k_q;
	ssbk_pkg::rec_t             hold_q;

	logic                       load_acc;
	logic                       room;
	logic [ssbk_pkg::CNT_W-1:0] count_new;
	logic [ssbk_pkg::CNT_W-1:0] jg;
	logic [ssbk_pkg::IDX_W-1:0] jg_idx;
	logic [ssbk_pkg::CNT_W-1:0] i_minus_gap;
	logic [ssbk_pkg::CNT_W-1:0] j_minus_gap;
	logic [ssbk_pkg::CNT_W-1:0] k_next;
	logic                       i_done;
	logic                       key_gt;
	logic                       j_ge_gap;
	logic                       k_last;

	assign load_acc    = load_valid && !load_stall;
	assign room        = count_q < ssbk_pkg::CNT_W'(ssbk_pkg::MAX_RECORDS);
	assign count_new   = room ? count_q + ssbk_pkg::CNT_W'(1) : count_q;
	assign jg          = ssbk_pkg::CNT_W'(j_q) + gap_q;
	assign jg_idx      = jg[ssbk_pkg::IDX_W-1:0];
	assign i_minus_gap = i_q - gap_q;
	assign j_minus_gap = ssbk_pkg::CNT_W'(j_q) - gap_q;
	assign k_next      = ssbk_pkg::CNT_W'(k_q) + ssbk_pkg::CNT_W'(1);
	assign i_done      = i_q >= count_q;
	// The single key comparator of the block: earlier key strictly greater than later key.
	assign key_gt      = rdata_a.key > rdata_b.key;
	assign j_ge_gap    = ssbk_pkg::CNT_W'(j_q) >= gap_q;
	assign k_last      = k_next == count_q;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ssbk_pkg::ST_LOAD: begin
				if (load_acc && last_in) state_nxt = ssbk_pkg::ST_GAP;
			end
			ssbk_pkg::ST_GAP: begin
				if (gap_q == '0) state_nxt = ssbk_pkg::ST_EMIT_RD;
				else state_nxt = ssbk_pkg::ST_PASS;
			end
			ssbk_pkg::ST_PASS: begin
				if (i_done) state_nxt = ssbk_pkg::ST_GAP;
				else state_nxt = ssbk_pkg::ST_READ;
			end
			ssbk_pkg::ST_READ: begin
				state_nxt = ssbk_pkg::ST_CMP;
			end
			ssbk_pkg::ST_CMP: begin
				if (key_gt) state_nxt = ssbk_pkg::ST_SWAP;
				else state_nxt = ssbk_pkg::ST_PASS;
			end
			ssbk_pkg::ST_SWAP: begin
				if (j_ge_gap) state_nxt = ssbk_pkg::ST_READ;
				else state_nxt = ssbk_pkg::ST_PASS;
			end
			ssbk_pkg::ST_EMIT_RD: begin
				state_nxt = ssbk_pkg::ST_EMIT_WR;
			end
			ssbk_pkg::ST_EMIT_WR: begin
				if (!out_busy) begin
					if (k_last) state_nxt = ssbk_pkg::ST_LOAD;
					else state_nxt = ssbk_pkg::ST_EMIT_RD;
				end
			end
			default: state_nxt = ssbk_pkg::ST_LOAD;
		endcase
	end

	// Outputs: store requests and output register control.
	always_comb begin
		load_stall    = state_q != ssbk_pkg::ST_LOAD;
		mem_req.we    = 1'b0;
		mem_req.waddr = j_q;
		mem_req.wdata = hold_q;
		mem_req.raddr_a = j_q;
		mem_req.raddr_b = jg_idx;
		emit.load     = 1'b0;
		emit.last     = k_last;
		emit.ovf      = ovf_q;
		unique case (state_q)
			ssbk_pkg::ST_LOAD: begin
				mem_req.we          = load_valid && room;
				mem_req.waddr       = count_q[ssbk_pkg::IDX_W-1:0];
				mem_req.wdata.key     = key;
				mem_req.wdata.payload = payload;
			end
			ssbk_pkg::ST_CMP: begin
				// First half of an exchange: the larger record moves up by one gap.
				mem_req.we    = key_gt;
				mem_req.waddr = jg_idx;
				mem_req.wdata = rdata_a;
			end
			ssbk_pkg::ST_SWAP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = j_q;
				mem_req.wdata = hold_q;
			end
			ssbk_pkg::ST_EMIT_RD: begin
				mem_req.raddr_a = k_q;
			end
			ssbk_pkg::ST_EMIT_WR: begin
				mem_req.raddr_a = k_q;
				emit.load       = !out_busy;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssbk_pkg::ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
			gap_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				ssbk_pkg::ST_LOAD: begin
					if (load_acc) begin
						count_q <= count_new;
						if (!room) ovf_q <= 1'b1;
						gap_q <= count_new >> 1;
					end
				end
				ssbk_pkg::ST_GAP: begin
					i_q <= gap_q;
					k_q <= '0;
				end
				ssbk_pkg::ST_PASS: begin
					if (i_done) gap_q <= gap_q >> 1;
					else j_q <= i_minus_gap[ssbk_pkg::IDX_W-1:0];
				end
				ssbk_pkg::ST_CMP: begin
					if (!key_gt) i_q <= i_q + ssbk_pkg::CNT_W'(1);
				end
				ssbk_pkg::ST_SWAP: begin
					if (j_ge_gap) j_q <= j_minus_gap[ssbk_pkg::IDX_W-1:0];
					else i_q <= i_q + ssbk_pkg::CNT_W'(1);
				end
				ssbk_pkg::ST_EMIT_WR: begin
					if (!out_busy) begin
						k_q <= k_next[ssbk_pkg::IDX_W-1:0];
						if (k_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Lower record of a pending exchange, written back in the following cycle.
	always_ff @(posedge clk) begin
		if (state_q == ssbk_pkg::ST_CMP) begin
			hold_q <= rdata_b;
		end
	end

endmodule

// ----- rtl/shell_sort_by_key.sv -----
// Shell sort by key. Records (a 32-bit unsigned key and a payload) are taken one word per
// cycle on the load channel until a word carrying last_in; up to MAX_RECORDS records are
// kept and any further ones are dropped, which sets overflowed on every word of that set's
// output. The set is then sorted in place into ascending key order, with the gap starting
// at half the count and halved each round, and emitted on the emit channel with last_out
// on the final word. The sort runs on a single key comparator and a store with one write
// port and two registered read ports. Each insertion step has a setup state, each compare
// adds a registered read of both records followed by the comparison, and each exchange
// adds a state that writes the lower record back. Each gap round adds a gap state and the
// pass that closes it, and the end of the sort one more gap state. A set of n records has
// s insertion steps (the sum over the gaps g of n - g, a little under n * log2(n)) and c
// compares; c equals s for a set already in order and grows towards n squared for adverse
// orders. Each record is emitted by a read of the store and then a load of the output
// register, which waits while that register holds an untaken word. The load channel stalls
// from the last record of a set until its final sorted word has entered the output register.
module shell_sort_by_key (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load_valid,
	output logic                              load_stall,
	input  logic [ssbk_pkg::KEY_BITS-1:0]     key,
	input  logic [ssbk_pkg::PAYLOAD_BITS-1:0] payload,
	input  logic                              last_in,
	output logic                              emit_valid,
	input  logic                              emit_stall,
	output logic [ssbk_pkg::KEY_BITS-1:0]     sorted_key,
	output logic [ssbk_pkg::PAYLOAD_BITS-1:0] sorted_payload,
	output logic                              last_out,
	output logic                              overflowed
);

	ssbk_pkg::mem_req_t  mem_req;
	ssbk_pkg::rec_t      rdata_a;
	ssbk_pkg::rec_t      rdata_b;
	ssbk_pkg::emit_ctl_t emit;
	logic                emit_valid_q;
	logic                out_busy;

	// The output register is full and its word is not being taken this cycle.
	assign out_busy   = emit_valid_q && emit_stall;
	assign emit_valid = emit_valid_q;

	ssbk_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	ssbk_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.load_stall (load_stall),
		.key        (key),
		.payload    (payload),
		.last_in    (last_in),
		.rdata_a    (rdata_a),
		.rdata_b    (rdata_b),
		.out_busy   (out_busy),
		.mem_req    (mem_req),
		.emit       (emit)
	);

	// Output register: valid is cleared once its word is taken, unless a new one arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_valid_q <= 1'b0;
		end else if (emit.load) begin
			emit_valid_q <= 1'b1;
		end else if (!emit_stall) begin
			emit_valid_q <= 1'b0;
		end
	end

	// The payload of the output word needs no reset.
	always_ff @(posedge clk) begin
		if (emit.load) begin
			sorted_key     <= rdata_a.key;
			sorted_payload <= rdata_a.payload;
			last_out       <= emit.last;
			overflowed     <= emit.ovf;
		end
	end

endmodule
